>>> rtl/core/rlps_pkg.sv
// ----------------------------------------------------------------------------
// rlps_pkg
// Types and constants shared by the RGB LED pulse serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package rlps_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       latch;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  pulse_count;
    logic [11:0] wait_us;
    logic        last_bit;
  } out_item_t;

  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned CNT_W      = $clog2(FRAME_BITS);

  typedef struct packed {
    logic [FRAME_BITS-1:0] bits;
    logic                  latch;
  } frame_t;

  // downstream handshake between frame pipeline and serializer
  typedef struct packed {
    logic valid;
    logic take;
  } pipe_hs_t;

  localparam logic [7:0]  FRAME_HEADER = 8'h3A;
  // x / 100 == (x * 5243) >> 19 for every x below 2^15
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int unsigned RECIP_SHIFT  = 19;
  localparam logic [3:0]  SHORT_GAP    = 4'd3;
  localparam logic [3:0]  LATCH_GAP    = 4'd10;

  localparam logic [1:0]  PULSES_ZERO  = 2'd1;
  localparam logic [1:0]  PULSES_ONE   = 2'd2;

  localparam logic [1:0]  CFG_BRIGHTNESS = 2'd0;
  localparam logic [1:0]  CFG_BIT_PERIOD = 2'd1;

  localparam logic [6:0]  BRIGHTNESS_RST = 7'd1;
  localparam logic [7:0]  BIT_PERIOD_RST = 8'd10;

endpackage

`default_nettype wire

>>> rtl/core/rlps_frame_pipe.sv
// ----------------------------------------------------------------------------
// rlps_frame_pipe
// Three-stage pipeline: brightness multiply, reciprocal multiply for the
// divide by 100, then saturation and frame assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module rlps_frame_pipe (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire rlps_pkg::in_item_t in_data,
  output logic                   in_stall,
  input  wire logic [6:0]        brightness,
  output rlps_pkg::pipe_hs_t     dn_hs_valid,
  input  wire logic              dn_take,
  output rlps_pkg::frame_t       frame
);

  logic        s1_v_r, s2_v_r, s3_v_r;
  logic        s1_v_nxt, s2_v_nxt, s3_v_nxt;
  logic        en1, en2, en3;

  logic [14:0] prod_r [3];
  logic        latch1_r;
  logic [27:0] recip_r [3];
  logic        latch2_r;
  rlps_pkg::frame_t frame_r;

  logic [7:0]  ch_in [3];
  logic [7:0]  ch_sat [3];
  logic [8:0]  quot [3];

  assign ch_in[0] = in_data.red;
  assign ch_in[1] = in_data.green;
  assign ch_in[2] = in_data.blue;

  assign en3 = !s3_v_r || dn_take;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;
  assign in_stall = !en1;

  always_comb begin
    s1_v_nxt = en1 ? in_valid : s1_v_r;
    s2_v_nxt = en2 ? s1_v_r : s2_v_r;
    s3_v_nxt = en3 ? s2_v_r : s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quot[i]   = recip_r[i][rlps_pkg::RECIP_SHIFT +: 9];
      ch_sat[i] = quot[i][8] ? 8'hFF : quot[i][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= {7'd0, ch_in[i]} * {8'd0, brightness};
      end
      latch1_r <= in_data.latch;
    end
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        recip_r[i] <= {13'd0, prod_r[i]} * {15'd0, rlps_pkg::RECIP_100};
      end
      latch2_r <= latch1_r;
    end
    if (en3) begin
      frame_r.bits  <= {rlps_pkg::FRAME_HEADER, ch_sat[2], ch_sat[1], ch_sat[0]};
      frame_r.latch <= latch2_r;
    end
  end

  assign dn_hs_valid.valid = s3_v_r;
  assign dn_hs_valid.take  = dn_take && s3_v_r;
  assign frame = frame_r;

endmodule

`default_nettype wire

>>> rtl/core/rgb_led_pulse_serializer_unit.sv
// ----------------------------------------------------------------------------
// rgb_led_pulse_serializer_unit
// Scales an RGB color by brightness and serializes the 32-bit frame into
// one pulse symbol per bit.
//
//   port group  | direction | transfer
//   in_*        | input     | one color and latch flag
//   out_*       | output    | one bit symbol, 32 per color
//   cfg_*       | input     | register write, no handshake
//
// A color gives 32 symbols at the output, one symbol per cycle while out_stall
// is low; the single output symbol register sets that rate. From the input
// transfer a color passes the three arithmetic stages before its first symbol.
// The next color is accepted while the current frame still shifts out.
// Reset clears all valid bits and loads register defaults; out_stall holds
// the current symbol and backs up the pipeline stage by stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_pulse_serializer_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire rlps_pkg::in_item_t  in_data,
  output logic                     in_stall,
  output logic                     out_valid,
  output rlps_pkg::out_item_t      out_data,
  input  wire logic                out_stall,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_wdata
);

  logic [6:0] brightness_r;
  logic [7:0] bit_period_r;

  logic                      busy_r, busy_nxt;
  logic [rlps_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [rlps_pkg::FRAME_BITS-1:0] shift_r, shift_nxt;
  logic                      latch_r, latch_nxt;

  logic               ser_free;
  logic               out_xfer;
  logic               last;
  logic [3:0]         gap;
  rlps_pkg::pipe_hs_t hs;
  rlps_pkg::frame_t   frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= rlps_pkg::BRIGHTNESS_RST;
      bit_period_r <= rlps_pkg::BIT_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rlps_pkg::CFG_BRIGHTNESS: brightness_r <= cfg_wdata[6:0];
        rlps_pkg::CFG_BIT_PERIOD: bit_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rlps_frame_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .brightness  (brightness_r),
    .dn_hs_valid (hs),
    .dn_take     (ser_free),
    .frame       (frame)
  );

  assign last     = (cnt_r == rlps_pkg::CNT_W'(rlps_pkg::FRAME_BITS - 1));
  assign out_xfer = busy_r && !out_stall;
  assign ser_free = !busy_r || (out_xfer && last);

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    latch_nxt = latch_r;
    if (hs.valid && hs.take) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      shift_nxt = frame.bits;
      latch_nxt = frame.latch;
    end else if (out_xfer) begin
      busy_nxt  = !last;
      cnt_nxt   = cnt_r + 1'b1;
      shift_nxt = {shift_r[rlps_pkg::FRAME_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    latch_r <= latch_nxt;
  end

  assign gap = latch_r ? rlps_pkg::LATCH_GAP : rlps_pkg::SHORT_GAP;

  assign out_valid            = busy_r;
  assign out_data.pulse_count = shift_r[rlps_pkg::FRAME_BITS-1] ? rlps_pkg::PULSES_ONE
                                                               : rlps_pkg::PULSES_ZERO;
  assign out_data.wait_us     = last ? {4'd0, bit_period_r} * (12'(gap) + 12'd1)
                                     : {4'd0, bit_period_r};
  assign out_data.last_bit    = last;

endmodule

`default_nettype wire

>>> sim/rgb_led_pulse_serializer_unit_test.sv
// ----------------------------------------------------------------------------
// rgb_led_pulse_serializer_unit_test
// Drives colors through the serializer under random sender and receiver
// stalls, predicts the 32 bit symbols of every frame from the brightness and
// bit period settings, and compares each symbol transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_pulse_serializer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_GAP       = 40;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [1:0]  CFG_SPARE     = 2'd3;

  class led_frame_scoreboard;
    rlps_pkg::out_item_t symbols_q[$];
    logic [6:0] brightness;
    logic [7:0] bit_period;
    int         errors;

    function new();
      brightness = rlps_pkg::BRIGHTNESS_RST;
      bit_period = rlps_pkg::BIT_PERIOD_RST;
      errors     = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] val);
      if (idx == rlps_pkg::CFG_BRIGHTNESS) begin
        brightness = val[6:0];
      end else if (idx == rlps_pkg::CFG_BIT_PERIOD) begin
        bit_period = val;
      end
    endfunction

    function logic [7:0] scaled(logic [7:0] level);
      int unsigned s;
      s = (32'(level) * 32'(brightness)) / 100;
      if (s > 255) s = 255;
      return s[7:0];
    endfunction

    function void note_color(rlps_pkg::in_item_t item);
      logic [31:0] frame;
      rlps_pkg::out_item_t sym;
      int unsigned gap;
      int unsigned w;
      frame = {rlps_pkg::FRAME_HEADER, scaled(item.blue), scaled(item.green),
               scaled(item.red)};
      gap   = item.latch ? 32'(rlps_pkg::LATCH_GAP) : 32'(rlps_pkg::SHORT_GAP);
      for (int i = 31; i >= 0; i--) begin
        w = 32'(bit_period);
        if (i == 0) w = w * (gap + 1);
        sym.pulse_count = frame[i] ? rlps_pkg::PULSES_ONE : rlps_pkg::PULSES_ZERO;
        sym.wait_us     = w[11:0];
        sym.last_bit    = (i == 0);
        symbols_q.push_back(sym);
      end
    endfunction

    function void check_symbol(rlps_pkg::out_item_t got);
      rlps_pkg::out_item_t exp_sym;
      if (symbols_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected symbol: pulses %0d wait %0d last %0d",
                   got.pulse_count, got.wait_us, got.last_bit);
        return;
      end
      exp_sym = symbols_q.pop_front();
      if (got.pulse_count !== exp_sym.pulse_count || got.wait_us !== exp_sym.wait_us ||
          got.last_bit !== exp_sym.last_bit) begin
        errors++;
        if (errors <= 10)
          $display("symbol mismatch: exp pulses %0d wait %0d last %0d, got %0d %0d %0d",
                   exp_sym.pulse_count, exp_sym.wait_us, exp_sym.last_bit,
                   got.pulse_count, got.wait_us, got.last_bit);
      end
    endfunction

    function int pending();
      return symbols_q.size();
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  rlps_pkg::in_item_t  in_data   = '0;
  logic                in_stall;
  logic                out_valid;
  rlps_pkg::out_item_t out_data;
  logic                out_stall = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_index = rlps_pkg::CFG_BRIGHTNESS;
  logic [7:0]          cfg_wdata = '0;

  int unsigned tx_idle_pct = 32;
  int unsigned rx_idle_pct = 82;
  int unsigned cycles      = 0;

  led_frame_scoreboard sb = new();

  rgb_led_pulse_serializer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_symbol(out_data);
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, val);
    @(posedge clk);
  endtask

  task automatic send_color(input rlps_pkg::in_item_t item);
    int unsigned gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < MAX_GAP) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.note_color(item);
  endtask

  // sender holds off until the last symbol has drained
  task automatic wait_frames_done();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_level();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic run_random(input int unsigned n);
    rlps_pkg::in_item_t item;
    if ($urandom_range(1)) write_reg(rlps_pkg::CFG_BRIGHTNESS, 8'($urandom_range(255)));
    else write_reg(rlps_pkg::CFG_BRIGHTNESS, 8'($urandom_range(100, 1)));
    write_reg(rlps_pkg::CFG_BIT_PERIOD, 8'($urandom_range(255)));
    for (int i = 0; i < n; i++) begin
      item.red   = rand_level();
      item.green = rand_level();
      item.blue  = rand_level();
      item.latch = 1'($urandom_range(1));
      send_color(item);
    end
    wait_frames_done();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults
    send_color(rlps_pkg::in_item_t'{8'd255, 8'd100, 8'd50, 1'b0});
    send_color(rlps_pkg::in_item_t'{8'd99, 8'd200, 8'd255, 1'b1});
    wait_frames_done();

    // full brightness, shortest nonzero period
    write_reg(rlps_pkg::CFG_BRIGHTNESS, 8'd100);
    write_reg(rlps_pkg::CFG_BIT_PERIOD, 8'd1);
    send_color(rlps_pkg::in_item_t'{8'h00, 8'h00, 8'h00, 1'b0});
    send_color(rlps_pkg::in_item_t'{8'hFF, 8'hFF, 8'hFF, 1'b1});
    send_color(rlps_pkg::in_item_t'{8'hAA, 8'h55, 8'h0F, 1'b0});
    send_color(rlps_pkg::in_item_t'{8'h55, 8'hAA, 8'hF0, 1'b1});
    send_color(rlps_pkg::in_item_t'{8'h01, 8'h80, 8'h7F, 1'b0});
    wait_frames_done();

    // brightness above 100 saturates; bit 7 of the write data is dropped
    write_reg(rlps_pkg::CFG_BRIGHTNESS, 8'hFF);
    write_reg(rlps_pkg::CFG_BIT_PERIOD, 8'd255);
    send_color(rlps_pkg::in_item_t'{8'd255, 8'd255, 8'd255, 1'b1});
    send_color(rlps_pkg::in_item_t'{8'd200, 8'd100, 8'd2, 1'b0});
    send_color(rlps_pkg::in_item_t'{8'd81, 8'd80, 8'd79, 1'b1});
    wait_frames_done();

    // zero brightness and zero period
    write_reg(rlps_pkg::CFG_BRIGHTNESS, 8'd0);
    write_reg(rlps_pkg::CFG_BIT_PERIOD, 8'd0);
    send_color(rlps_pkg::in_item_t'{8'd255, 8'd255, 8'd255, 1'b1});
    send_color(rlps_pkg::in_item_t'{8'd17, 8'd34, 8'd51, 1'b0});
    wait_frames_done();

    // unused index must leave both registers alone
    write_reg(rlps_pkg::CFG_BRIGHTNESS, 8'd50);
    write_reg(rlps_pkg::CFG_BIT_PERIOD, 8'd2);
    write_reg(CFG_SPARE, 8'hFF);
    send_color(rlps_pkg::in_item_t'{8'd199, 8'd99, 8'd1, 1'b1});
    wait_frames_done();

    for (int k = 0; k < 3; k++) run_random(20);

    tx_idle_pct = 82;
    rx_idle_pct = 32;
    for (int k = 0; k < 3; k++) run_random(20);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int k = 0; k < 3; k++) run_random(13);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
